// ----- rtl/core/tnd_pkg.sv -----
// ----------------------------------------------------------------------------
// tnd_pkg: shared types and constants for the tree distance core
// Table sizes, field widths, opcodes, controller states and the
// command/status bundle between controller and datapath.
// ----------------------------------------------------------------------------
package tnd_pkg;

  // table geometry
  localparam int MAX_NODES  = 1024;
  localparam int MAX_LEVELS = 10;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int LEVEL_W    = $clog2(MAX_LEVELS);
  localparam int ANC_DEPTH  = MAX_LEVELS * MAX_NODES;
  localparam int ANC_AW     = LEVEL_W + NODE_W;

  // field widths
  localparam int OP_W       = 2;
  localparam int DEPTH_W    = 10;
  localparam int CNT_W      = 11;
  localparam int LVLCFG_W   = 4;
  localparam int DIST_W     = 11;
  localparam int ANC_W      = NODE_W + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  // ancestor entry: top bit set means "no ancestor"
  localparam int                 NO_ANC_BIT = NODE_W;
  localparam logic [ANC_W-1:0]   NO_ANC     = {1'b1, {NODE_W{1'b0}}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVELS_USED = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_BUILD_RD_SELF,
    ST_BUILD_RD_UP,
    ST_BUILD_WR,
    ST_Q_SETUP,
    ST_Q_LIFT,
    ST_Q_LIFT_UPD,
    ST_Q_MEET,
    ST_Q_JOINT,
    ST_Q_JOINT_UPD,
    ST_Q_PAR,
    ST_Q_PAR_UPD,
    ST_Q_EMIT
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_LOAD,
    CMD_BUILD_INIT,
    CMD_BUILD_RD_SELF,
    CMD_BUILD_RD_UP,
    CMD_BUILD_WR,
    CMD_Q_DEPTH_RD,
    CMD_Q_SETUP,
    CMD_Q_LIFT_RD,
    CMD_Q_LIFT_UPD,
    CMD_Q_MEET,
    CMD_Q_JOINT_RD,
    CMD_Q_JOINT_UPD,
    CMD_Q_PAR_RD,
    CMD_Q_PAR_UPD,
    CMD_Q_EMIT
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            build_empty;
    logic            build_last_node;
    logic            build_last_level;
    logic            d_zero;
    logic            lift_blocked;
    logic            same_node;
    logic            level_zero;
    logic            out_busy;
  } status_t;

endpackage

// ----- rtl/core/tree_node_distance_lca_core.sv -----
// ----------------------------------------------------------------------------
// tree_node_distance_lca_core: rooted-tree distance by binary lifting
// Top level: stream ports, configuration registers and the
// controller/datapath pair.
// ----------------------------------------------------------------------------
// Usage
//   s_* carries one transaction per item; s_tuser is the opcode (load node,
//   build jump table, query distance). A load writes a node's depth and
//   parent; a build fills jump levels 1..levels_used for nodes
//   0..node_count-1 from level 0; a query returns one distance on m_*.
//   Loads and builds produce nothing on m_*.
//   Items are taken one at a time. A load writes one depth entry and one
//   level-0 ancestor entry. A build does, per entry, a read, a dependent
//   read addressed by its result, and a write of the ancestor memory. A
//   query reads both depths, lifts the deeper node with one table read per
//   lifting step, steps the pair down from levels_used to level zero unless
//   they already coincide, then reads the depth of the meeting node.
//   The result appears on m_tvalid the cycle after the query finishes and
//   sits in an output register; the next item is accepted meanwhile. A
//   second query stalls in its final step until m_tready frees the register.
//   Reset (rst, synchronous) clears control state and sets node_count to
//   1024 and levels_used to 9; table contents are undefined until loaded.
//   cfg_* is always ready; write only while no item is in flight.
// ----------------------------------------------------------------------------
module tree_node_distance_lca_core (
  input  logic                            clk,
  input  logic                            rst,
  // s_tdata: node[9:0], other_node[19:10], parent[29:20], has_parent[30],
  //          depth[40:31], zero[47:41]
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [47:0]                     s_tdata,
  // s_tuser: op[1:0]
  input  logic [tnd_pkg::OP_W-1:0]        s_tuser,
  // m_tdata: distance[10:0], zero[15:11]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [15:0]                     m_tdata,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tnd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tnd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tnd_pkg::*;

  logic [CNT_W-1:0]    node_count;
  logic [LVLCFG_W-1:0] levels_used;
  logic [CNT_W-1:0]    cnt_eff;
  logic [LEVEL_W-1:0]  top_lvl;
  logic [DIST_W-1:0]   distance;
  cmd_t                cmd;
  status_t             st;

  // configuration registers; the port never back-pressures
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= CNT_W'(1024);
      levels_used <= LVLCFG_W'(9);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NODE_COUNT:  node_count  <= cfg_data[CNT_W-1:0];
        REG_LEVELS_USED: levels_used <= cfg_data[LVLCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // out-of-range settings saturate to the table size
  assign cnt_eff = (node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count;
  assign top_lvl = (levels_used > LVLCFG_W'(MAX_LEVELS - 1)) ?
                   LEVEL_W'(MAX_LEVELS - 1) : LEVEL_W'(levels_used);

  tnd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  tnd_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .in_op         (s_tuser),
    .in_node       (s_tdata[9:0]),
    .in_other_node (s_tdata[19:10]),
    .in_parent     (s_tdata[29:20]),
    .in_has_parent (s_tdata[30]),
    .in_depth      (s_tdata[40:31]),
    .cnt_eff       (cnt_eff),
    .top_lvl       (top_lvl),
    .distance      (distance),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready)
  );

  assign m_tdata = {5'b0, distance};

endmodule

// ----- rtl/core/tnd_datapath.sv -----
// ----------------------------------------------------------------------------
// tnd_datapath: tables, working registers and result register
// Depth and ancestor-jump memories (two read ports, one write port each,
// registered reads) plus the build and query registers, driven by cmd.
// ----------------------------------------------------------------------------
module tnd_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  tnd_pkg::cmd_t                 cmd,
  output tnd_pkg::status_t              st,
  input  logic [tnd_pkg::OP_W-1:0]      in_op,
  input  logic [tnd_pkg::NODE_W-1:0]    in_node,
  input  logic [tnd_pkg::NODE_W-1:0]    in_other_node,
  input  logic [tnd_pkg::NODE_W-1:0]    in_parent,
  input  logic                          in_has_parent,
  input  logic [tnd_pkg::DEPTH_W-1:0]   in_depth,
  input  logic [tnd_pkg::CNT_W-1:0]     cnt_eff,
  input  logic [tnd_pkg::LEVEL_W-1:0]   top_lvl,
  output logic [tnd_pkg::DIST_W-1:0]    distance,
  output logic                          out_valid,
  input  logic                          out_ready
);
  import tnd_pkg::*;

  logic [DEPTH_W-1:0] dep_mem [MAX_NODES];
  logic [ANC_W-1:0]   anc_mem [ANC_DEPTH];

  // captured item
  logic [OP_W-1:0]    op_q;
  logic [NODE_W-1:0]  node_q, other_q, par_q;
  logic               hasp_q;
  logic [DEPTH_W-1:0] dep_q;

  // build and query working registers
  logic [LEVEL_W-1:0] lvl_q, jump_q, i_q;
  logic [NODE_W-1:0]  j_q, x_q, y_q;
  logic               up_none_q;
  logic [DEPTH_W-1:0] da_q, db_q, d_q;

  // memory ports
  logic               dep_we, dep_re_a, dep_re_b;
  logic [NODE_W-1:0]  dep_addr_a, dep_addr_b;
  logic [DEPTH_W-1:0] dep_rd_a, dep_rd_b;
  logic               anc_we, anc_re_a, anc_re_b;
  logic [ANC_AW-1:0]  anc_waddr, anc_addr_a, anc_addr_b;
  logic [ANC_W-1:0]   anc_wdata, anc_rd_a, anc_rd_b;

  logic [LEVEL_W-1:0] jump_c;
  logic [NODE_W-1:0]  meet_c;
  logic               joint_move;
  logic [DIST_W-1:0]  sum_c, twice_c;

  // jump level: highest set bit of the remaining difference, clamped
  always_comb begin
    logic [LEVEL_W-1:0] hb;
    hb = '0;
    for (int k = 0; k < NODE_W; k++) begin
      if (d_q[k]) hb = LEVEL_W'(k);
    end
    jump_c = (hb > LEVEL_W'(MAX_LEVELS - 1)) ? LEVEL_W'(MAX_LEVELS - 1) : hb;
  end

  assign meet_c     = anc_rd_a[NO_ANC_BIT] ? x_q : anc_rd_a[NODE_W-1:0];
  assign joint_move = !anc_rd_a[NO_ANC_BIT] && !anc_rd_b[NO_ANC_BIT] &&
                      (anc_rd_a != anc_rd_b);
  assign sum_c      = DIST_W'(da_q) + DIST_W'(db_q);
  assign twice_c    = {dep_rd_a, 1'b0};

  always_comb begin
    dep_we     = 1'b0;
    dep_re_a   = 1'b0;
    dep_re_b   = 1'b0;
    dep_addr_a = node_q;
    dep_addr_b = other_q;
    anc_we     = 1'b0;
    anc_re_a   = 1'b0;
    anc_re_b   = 1'b0;
    anc_waddr  = {lvl_q, j_q};
    anc_wdata  = up_none_q ? NO_ANC : anc_rd_a;
    anc_addr_a = {lvl_q - LEVEL_W'(1), j_q};
    anc_addr_b = {i_q, y_q};
    unique case (cmd)
      CMD_LOAD: begin
        dep_we    = 1'b1;
        anc_we    = 1'b1;
        anc_waddr = {LEVEL_W'(0), node_q};
        anc_wdata = hasp_q ? {1'b0, par_q} : NO_ANC;
      end
      CMD_BUILD_RD_SELF: anc_re_a = 1'b1;
      CMD_BUILD_RD_UP: begin
        anc_re_a   = 1'b1;
        anc_addr_a = {lvl_q - LEVEL_W'(1), anc_rd_a[NODE_W-1:0]};
      end
      CMD_BUILD_WR:   anc_we = 1'b1;
      CMD_Q_DEPTH_RD: begin
        dep_re_a = 1'b1;
        dep_re_b = 1'b1;
      end
      CMD_Q_LIFT_RD: begin
        anc_re_a   = 1'b1;
        anc_addr_a = {jump_c, y_q};
      end
      CMD_Q_MEET: begin
        dep_re_a   = 1'b1;
        dep_addr_a = y_q;
      end
      CMD_Q_JOINT_RD: begin
        anc_re_a   = 1'b1;
        anc_re_b   = 1'b1;
        anc_addr_a = {i_q, x_q};
      end
      CMD_Q_PAR_RD: begin
        anc_re_a   = 1'b1;
        anc_addr_a = {LEVEL_W'(0), x_q};
      end
      CMD_Q_PAR_UPD: begin
        dep_re_a   = 1'b1;
        dep_addr_a = meet_c;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dep_we)   dep_mem[node_q] <= dep_q;
    if (dep_re_a) dep_rd_a <= dep_mem[dep_addr_a];
    if (dep_re_b) dep_rd_b <= dep_mem[dep_addr_b];
  end

  always_ff @(posedge clk) begin
    if (anc_we)   anc_mem[anc_waddr] <= anc_wdata;
    if (anc_re_a) anc_rd_a <= anc_mem[anc_addr_a];
    if (anc_re_b) anc_rd_b <= anc_mem[anc_addr_b];
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_CAPTURE: begin
        op_q    <= in_op;
        node_q  <= in_node;
        other_q <= in_other_node;
        par_q   <= in_parent;
        hasp_q  <= in_has_parent;
        dep_q   <= in_depth;
      end
      CMD_BUILD_INIT: begin
        lvl_q <= LEVEL_W'(1);
        j_q   <= '0;
      end
      CMD_BUILD_RD_UP: up_none_q <= anc_rd_a[NO_ANC_BIT];
      CMD_BUILD_WR: begin
        if (st.build_last_node) begin
          j_q   <= '0;
          lvl_q <= lvl_q + LEVEL_W'(1);
        end else begin
          j_q <= j_q + NODE_W'(1);
        end
      end
      CMD_Q_SETUP: begin
        da_q <= dep_rd_a;
        db_q <= dep_rd_b;
        if (dep_rd_a > dep_rd_b) begin
          x_q <= other_q;
          y_q <= node_q;
          d_q <= dep_rd_a - dep_rd_b;
        end else begin
          x_q <= node_q;
          y_q <= other_q;
          d_q <= dep_rd_b - dep_rd_a;
        end
      end
      CMD_Q_LIFT_RD: jump_q <= jump_c;
      CMD_Q_LIFT_UPD: begin
        if (!anc_rd_a[NO_ANC_BIT]) begin
          y_q <= anc_rd_a[NODE_W-1:0];
          d_q <= d_q - (DEPTH_W'(1) << jump_q);
        end
      end
      CMD_Q_MEET: i_q <= top_lvl;
      CMD_Q_JOINT_UPD: begin
        if (joint_move) begin
          x_q <= anc_rd_a[NODE_W-1:0];
          y_q <= anc_rd_b[NODE_W-1:0];
        end
        i_q <= i_q - LEVEL_W'(1);
      end
      // inconsistent depths would go negative: floor at zero
      CMD_Q_EMIT: distance <= (sum_c < twice_c) ? '0 : sum_c - twice_c;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == CMD_Q_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    st.op               = op_q;
    st.build_empty      = (cnt_eff == '0) || (top_lvl == '0);
    st.build_last_node  = ({1'b0, j_q} == cnt_eff - CNT_W'(1));
    st.build_last_level = (lvl_q == top_lvl);
    st.d_zero           = (d_q == '0);
    st.lift_blocked     = anc_rd_a[NO_ANC_BIT];
    st.same_node        = (x_q == y_q);
    st.level_zero       = (i_q == '0);
    st.out_busy         = out_valid && !out_ready;
  end

  // a build write never lands on the level filled by loads
  a_build_level: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_BUILD_WR |-> lvl_q != '0)
    else $error("build write aimed at level zero");

  // a taken lift never jumps further than the remaining difference
  a_lift_bound: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_Q_LIFT_UPD && !anc_rd_a[NO_ANC_BIT] |->
      d_q >= (DEPTH_W'(1) << jump_q))
    else $error("lift overshoots depth difference");

  // a result never overwrites one that is still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_Q_EMIT |-> !(out_valid && !out_ready))
    else $error("result register overwritten while stalled");

endmodule

// ----- rtl/core/tnd_ctrl.sv -----
// ----------------------------------------------------------------------------
// tnd_ctrl: sequencing state machine
// Accepts one item at a time and steps the datapath through load, table
// build and the two lifting passes of a query.
// ----------------------------------------------------------------------------
module tnd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tnd_pkg::status_t  st,
  output tnd_pkg::cmd_t     cmd
);
  import tnd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:          if (in_valid) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        unique case (st.op)
          OP_BUILD: state_next = st.build_empty ? ST_IDLE : ST_BUILD_RD_SELF;
          OP_QUERY: state_next = ST_Q_SETUP;
          default:  state_next = ST_IDLE;
        endcase
      end
      ST_BUILD_RD_SELF: state_next = ST_BUILD_RD_UP;
      ST_BUILD_RD_UP:   state_next = ST_BUILD_WR;
      ST_BUILD_WR:      state_next = (st.build_last_node && st.build_last_level) ?
                                     ST_IDLE : ST_BUILD_RD_SELF;
      ST_Q_SETUP:       state_next = ST_Q_LIFT;
      ST_Q_LIFT:        state_next = st.d_zero ? ST_Q_MEET : ST_Q_LIFT_UPD;
      ST_Q_LIFT_UPD:    state_next = st.lift_blocked ? ST_Q_MEET : ST_Q_LIFT;
      ST_Q_MEET:        state_next = st.same_node ? ST_Q_EMIT : ST_Q_JOINT;
      ST_Q_JOINT:       state_next = ST_Q_JOINT_UPD;
      ST_Q_JOINT_UPD:   state_next = st.level_zero ? ST_Q_PAR : ST_Q_JOINT;
      ST_Q_PAR:         state_next = ST_Q_PAR_UPD;
      ST_Q_PAR_UPD:     state_next = ST_Q_EMIT;
      ST_Q_EMIT:        if (!st.out_busy) state_next = ST_IDLE;
      default:          state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = CMD_NONE;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = CMD_CAPTURE;
      end
      ST_DISPATCH: begin
        unique case (st.op)
          OP_LOAD:  cmd = CMD_LOAD;
          OP_BUILD: cmd = CMD_BUILD_INIT;
          OP_QUERY: cmd = CMD_Q_DEPTH_RD;
          default:  cmd = CMD_NONE;
        endcase
      end
      ST_BUILD_RD_SELF: cmd = CMD_BUILD_RD_SELF;
      ST_BUILD_RD_UP:   cmd = CMD_BUILD_RD_UP;
      ST_BUILD_WR:      cmd = CMD_BUILD_WR;
      ST_Q_SETUP:       cmd = CMD_Q_SETUP;
      ST_Q_LIFT:        cmd = st.d_zero ? CMD_NONE : CMD_Q_LIFT_RD;
      ST_Q_LIFT_UPD:    cmd = CMD_Q_LIFT_UPD;
      ST_Q_MEET:        cmd = CMD_Q_MEET;
      ST_Q_JOINT:       cmd = CMD_Q_JOINT_RD;
      ST_Q_JOINT_UPD:   cmd = CMD_Q_JOINT_UPD;
      ST_Q_PAR:         cmd = CMD_Q_PAR_RD;
      ST_Q_PAR_UPD:     cmd = CMD_Q_PAR_UPD;
      ST_Q_EMIT:        cmd = st.out_busy ? CMD_NONE : CMD_Q_EMIT;
      default:          cmd = CMD_NONE;
    endcase
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_DISPATCH)
    else $error("accepted transaction not dispatched");

  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_Q_EMIT && st.out_busy |=> state == ST_Q_EMIT)
    else $error("query left before its result was stored");

  a_build_exit: assert property (@(posedge clk) disable iff (rst)
    state == ST_BUILD_WR && !st.build_last_node |=> state == ST_BUILD_RD_SELF)
    else $error("build ended before the last node of a level");

endmodule

// ----- sim/tree_node_distance_lca_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tree_node_distance_lca_core_test: self-checking bench for the tree distance core
// Fills every table entry with a full forest first, so that no later read can
// reach an unwritten entry. It then runs a short set of hand-picked items and
// after that random phases. Each phase sets both registers, grows a fresh
// forest, rebuilds the jump table and queries distances. Expected distances
// come from a bench-side binary-lifting model that is updated on every
// accepted transaction. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tree_node_distance_lca_core_test;
  import tnd_pkg::*;

  localparam int                WATCHDOG_LIMIT = 200000; // must outlast the full 1024 x 9 build
  localparam int                SETTLE_CYCLES  = 64;
  localparam int                RANDOM_ITEMS   = 250;    // on top of the full-table fill
  localparam logic [OP_W-1:0]   OP_UNUSED      = 2'd3;   // block ignores it

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [NODE_W-1:0]  node;
    logic [NODE_W-1:0]  other;
    logic [NODE_W-1:0]  parent;
    logic               has_parent;
    logic [DEPTH_W-1:0] depth;
  } tree_item_t;

  // DUT inputs, all known from time zero
  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic [47:0]           s_tdata   = '0;  // node, other_node, parent, has_parent, depth, zero
  logic [OP_W-1:0]       s_tuser   = '0;  // op
  logic                  m_tready  = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  // DUT outputs
  logic                  s_tready;
  logic                  m_tvalid;
  logic [15:0]           m_tdata;         // distance, zero
  logic                  cfg_ready;

  // stimulus and checking bookkeeping
  tree_item_t            pending_items[$];
  tree_item_t            nxt;
  logic [DIST_W-1:0]     dist_due[$];
  int                    queued_count = 0;  // transactions handed to the driver
  int                    taken_count  = 0;  // transactions accepted by the core
  int                    stim_count   = 0;  // non-ignored items of the random part
  int                    src_rate     = 0;  // chance in eighths of a source idle burst
  int                    sink_rate    = 0;  // chance in eighths of a sink stall burst
  int                    src_hold     = 0;
  int                    sink_hold    = 0;
  int                    quiet_cycles = 0;
  int                    errors       = 0;

  // bench-side copy of the tree state and the registers
  logic [DEPTH_W-1:0]    depth_mem [MAX_NODES];
  logic [ANC_W-1:0]      jump_mem  [MAX_LEVELS][MAX_NODES];
  logic [CNT_W-1:0]      model_nodes;
  logic [LVLCFG_W-1:0]   model_levels;

  tree_node_distance_lca_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Binary-lifting model
  // --------------------------------------------------------------------------
  function automatic int msb_index(input int v);
    int r;
    r = 0;
    while (v > 1) begin
      v = v >> 1;
      r++;
    end
    return r;
  endfunction

  // levels_used beyond the table height acts as the top level
  function automatic int top_level_in_use();
    return (model_levels > MAX_LEVELS - 1) ? MAX_LEVELS - 1 : int'(model_levels);
  endfunction

  function automatic void rebuild_jumps();
    int top, cnt, lv, j;
    logic [ANC_W-1:0] up;
    top = top_level_in_use();
    cnt = (model_nodes > MAX_NODES) ? MAX_NODES : int'(model_nodes);
    for (lv = 1; lv <= top; lv++) begin
      for (j = 0; j < cnt; j++) begin
        up = jump_mem[lv-1][j];
        jump_mem[lv][j] = up[NO_ANC_BIT] ? NO_ANC : jump_mem[lv-1][up[NODE_W-1:0]];
      end
    end
  endfunction

  function automatic logic [DIST_W-1:0] tree_distance(input logic [NODE_W-1:0] a,
                                                      input logic [NODE_W-1:0] b);
    int da, db, dz, d, jump, lv, edges;
    logic [NODE_W-1:0] x, y, meet;
    logic [ANC_W-1:0]  up, ux, uy;
    logic              stuck;
    da = int'(depth_mem[a]);
    db = int'(depth_mem[b]);
    if (da > db) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    d = (da > db) ? da - db : db - da;
    stuck = 1'b0;
    // lift the deeper node; stop at the root if the jump runs off the tree
    while (d > 0 && !stuck) begin
      jump = msb_index(d);
      if (jump > MAX_LEVELS - 1) jump = MAX_LEVELS - 1;
      up = jump_mem[jump][y];
      if (up[NO_ANC_BIT]) begin
        stuck = 1'b1;
      end else begin
        y = up[NODE_W-1:0];
        d = d - (1 << jump);
      end
    end
    if (x != y) begin
      // move the pair only while both ancestors exist and still differ
      for (lv = top_level_in_use(); lv >= 0; lv--) begin
        ux = jump_mem[lv][x];
        uy = jump_mem[lv][y];
        if (!ux[NO_ANC_BIT] && !uy[NO_ANC_BIT] && ux != uy) begin
          x = ux[NODE_W-1:0];
          y = uy[NODE_W-1:0];
        end
      end
      up   = jump_mem[0][x];
      meet = up[NO_ANC_BIT] ? x : up[NODE_W-1:0];
    end else begin
      meet = y;
    end
    dz    = int'(depth_mem[meet]);
    edges = da + db - 2 * dz;
    if (edges < 0) edges = 0;
    return edges[DIST_W-1:0];
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    $display("[%0t] ERROR: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: follows every accepted transaction on all three channels
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      model_nodes  = 11'd1024;
      model_levels = 4'd9;
      dist_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_NODE_COUNT) model_nodes = cfg_data[CNT_W-1:0];
        else if (cfg_index == REG_LEVELS_USED) model_levels = cfg_data[LVLCFG_W-1:0];
      end
      if (s_tvalid && s_tready) begin
        taken_count++;
        case (s_tuser)
          OP_LOAD: begin
            depth_mem[s_tdata[9:0]]   = s_tdata[40:31];
            jump_mem[0][s_tdata[9:0]] = s_tdata[30] ? {1'b0, s_tdata[29:20]} : NO_ANC;
          end
          OP_BUILD: rebuild_jumps();
          OP_QUERY: dist_due.insert(dist_due.size(),
                                    tree_distance(s_tdata[9:0], s_tdata[19:10]));
          default: ;  // unused opcode: no effect, no result
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (dist_due.size() == 0)
          flag_error($sformatf("distance %0d with no query waiting", m_tdata[DIST_W-1:0]));
        else if (m_tdata[DIST_W-1:0] != dist_due[0])
          flag_error($sformatf("distance %0d, wanted %0d", m_tdata[DIST_W-1:0], dist_due[0]));
        if (dist_due.size() != 0) void'(dist_due.pop_front());
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: presents queued items, with random idle bursts between them
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_hold <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (src_hold != 0) begin
        src_hold <= src_hold - 1;
        s_tvalid <= 1'b0;
      end else if (pending_items.size() != 0 && $urandom_range(0, 7) < src_rate) begin
        src_hold <= $urandom_range(0, 7);   // start an idle burst of random length
        s_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        nxt = pending_items.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, nxt.depth, nxt.has_parent, nxt.parent, nxt.other, nxt.node};
        s_tuser  <= nxt.op;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result sink with random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      sink_hold <= 0;
    end else if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      m_tready  <= 1'b0;
    end else if ($urandom_range(0, 7) < sink_rate) begin
      sink_hold <= $urandom_range(0, 7);
      m_tready  <= 1'b0;
    end else begin
      m_tready  <= 1'b1;
    end
  end

  // watchdog: too long without any transaction on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int any10();
    return $urandom_range(0, MAX_NODES - 1);
  endfunction

  task automatic queue_item(input logic [OP_W-1:0] op, input int node, input int other,
                            input int parent, input int has_parent, input int depth);
    tree_item_t it;
    it.op         = op;
    it.node       = NODE_W'(node);
    it.other      = NODE_W'(other);
    it.parent     = NODE_W'(parent);
    it.has_parent = has_parent[0];
    it.depth      = DEPTH_W'(depth);
    pending_items.insert(pending_items.size(), it);
    queued_count++;
    if (op != OP_UNUSED) stim_count++;
  endtask

  task automatic queue_query(input int a, input int b);
    queue_item(OP_QUERY, a, b, any10(), $urandom_range(0, 1), any10());
  endtask

  task automatic queue_build();
    queue_item(OP_BUILD, any10(), any10(), any10(), $urandom_range(0, 1), any10());
  endtask

  // mostly a node of the current forest, now and then any node at all
  function automatic int pick_node(input int base, input int span);
    if ($urandom_range(0, 7) == 0) return any10();
    return base + $urandom_range(0, span - 1);
  endfunction

  // fresh forest on nodes base..base+span-1: parents always lower-indexed,
  // chains now and then for deep lifts, the odd depth that does not fit
  task automatic grow_forest(input int base, input int span);
    int i, p, dep;
    int dep_of [MAX_NODES];
    for (i = 0; i < span; i++) begin
      if (i == 0 || $urandom_range(0, 15) == 0) begin
        dep = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 255);
        queue_item(OP_LOAD, base + i, any10(), any10(), 0, dep);
      end else begin
        p   = ($urandom_range(0, 2) == 0) ? i - 1 : $urandom_range(0, i - 1);
        dep = dep_of[p] + 1;
        if (dep > 1023) dep = 1023;
        if ($urandom_range(0, 31) == 0) dep = $urandom_range(0, 1023);
        queue_item(OP_LOAD, base + i, any10(), base + p, 1, dep);
      end
      dep_of[i] = dep;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // every item taken, every distance back, then a quiet spell
  task automatic settle();
    do @(posedge clk); while (taken_count != queued_count || dist_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int phase, span, base, nq, q, lv;
    logic [CFG_DATA_W-1:0] cfg_word;
    logic big;

    for (int i = 0; i < MAX_NODES; i++) begin
      depth_mem[i] = '0;
      for (int k = 0; k < MAX_LEVELS; k++) jump_mem[k][i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Full-size build over all nodes and levels: from here on every table
    // entry holds a value, so any later item is legal.
    write_reg(REG_NODE_COUNT, 11'd1024);
    write_reg(REG_LEVELS_USED, 11'd9);
    src_rate  = 1;
    sink_rate = 1;
    grow_forest(0, MAX_NODES);
    queue_build();

    // Hand-picked items on the highest and lowest indices
    queue_item(OP_LOAD, 1023, any10(), 1023, 0, 0);    // root, parent field ignored
    queue_item(OP_LOAD,    0, any10(), 1023, 1, 1);
    queue_item(OP_LOAD,  512, any10(),    0, 1, 2);
    queue_item(OP_LOAD,  511, any10(), 1023, 1, 1);
    queue_item(OP_LOAD,  300, any10(),  511, 1, 1023); // depth far beyond the real one
    queue_item(OP_LOAD,  301, any10(), 1023, 1, 1023);
    queue_item(OP_LOAD,  700, any10(),    0, 0, 5);    // root of a separate tree
    queue_item(OP_LOAD,  900, any10(),    0, 0, 1023);
    queue_item(OP_LOAD,  901, any10(),  900, 1, 0);    // parent deeper than its child
    queue_build();
    queue_query(512, 511);
    queue_query(511, 512);
    queue_query(1023, 1023);  // same node
    queue_query(0, 512);      // one is the other's ancestor
    queue_query(300, 0);      // top-level lift that runs past the root
    queue_query(700, 512);    // different trees, no shared ancestor
    queue_item(OP_UNUSED, 1023, 1023, 1023, 1, 1023);
    queue_query(901, 900);    // depths give a negative distance, clipped to zero
    queue_query(300, 301);    // largest distance
    settle();

    // Random phases: registers, fresh forest, build, a burst of queries
    stim_count = 0;
    phase      = 0;
    while (stim_count < RANDOM_ITEMS) begin
      big = (phase == 2 || phase == 4);
      if (big) begin
        span = $urandom_range(60, 120);
        base = $urandom_range(0, MAX_NODES - span);
        cfg_word = (phase == 2) ? 11'd2047 : 11'd1024;  // above the table size, and at it
        lv   = 9;
      end else begin
        span = $urandom_range(2, 48);
        base = 0;
        if (phase == 0) begin
          cfg_word = 11'd1;
          lv       = 0;
        end else if (phase == 1) begin
          cfg_word = 11'd0;   // build touches nothing
          lv       = 15;
        end else begin
          cfg_word = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, span)) :
                                                   CFG_DATA_W'(span);
          lv       = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 9;
        end
      end
      write_reg(REG_NODE_COUNT, cfg_word);
      cfg_word = CFG_DATA_W'($urandom);
      cfg_word[LVLCFG_W-1:0] = LVLCFG_W'(lv);
      write_reg(REG_LEVELS_USED, cfg_word);

      // vary the idling; none at all towards the end
      if (stim_count > RANDOM_ITEMS - 60) begin
        src_rate  = 0;
        sink_rate = 0;
      end else begin
        src_rate  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
        sink_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
      end

      grow_forest(base, span);
      if ($urandom_range(0, 5) == 0) begin
        // queries against the stale table before the rebuild
        queue_query(pick_node(base, span), pick_node(base, span));
        queue_query(pick_node(base, span), pick_node(base, span));
      end
      queue_build();
      if ($urandom_range(0, 9) == 0) queue_build();
      nq = $urandom_range(6, 30);
      for (q = 0; q < nq; q++) begin
        if ($urandom_range(0, 19) == 0)
          queue_item(OP_UNUSED, any10(), any10(), any10(), $urandom_range(0, 1), any10());
        queue_query(pick_node(base, span), pick_node(base, span));
      end
      settle();
      phase++;
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
